FILE: rtl/sxf_pkg.sv
package sxf_pkg;

    localparam int SAMPLE_BITS_DEFAULT    = 24;
    localparam int GAIN_FRAC_BITS_DEFAULT = 15;

    localparam int LEVEL_BITS = 16;
    localparam int LEVEL_FRAC = 14;
    localparam int POS_BITS   = 16;

    localparam int SINE_FRAC = 30;
    localparam int SINE_BITS = 31;
    localparam int ZQ_BITS   = 17;

    localparam int HORNER_STEPS = 4;
    localparam int NUM_STAGES   = 12;

    localparam logic [SINE_BITS-1:0] SINE_C9 = 31'd172272;

    localparam logic [SINE_BITS-1:0] SINE_COEF [HORNER_STEPS] = '{
        31'd5026995,
        31'd85569304,
        31'd693598670,
        31'd1686629713
    };

    typedef enum logic
    {
        PAN_SINE   = 1'b0,
        PAN_LINEAR = 1'b1
    } pan_law_t;

    localparam int LANE_LEFT  = 0;
    localparam int LANE_RIGHT = 1;

endpackage

FILE: rtl/stereo_crossfader_pan_law_unit.sv
// Throughput: one item per cycle; a new item enters every cycle the pipe can advance.
// The equal-power gains come from two sine evaluators, one Horner multiply per stage.
// A stall collapses bubbles, so each stage holds only while it is full and the stage after it cannot load.
// Reset (rst_n low, asynchronous) empties the pipeline and selects the equal-power law.
module stereo_crossfader_pan_law_unit #(
    parameter int SAMPLE_BITS    = sxf_pkg::SAMPLE_BITS_DEFAULT,
    parameter int GAIN_FRAC_BITS = sxf_pkg::GAIN_FRAC_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  pan_law,

    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic signed [SAMPLE_BITS-1:0]         left_sample,
    input  logic signed [SAMPLE_BITS-1:0]         right_sample,
    input  logic signed [sxf_pkg::POS_BITS-1:0]   fade_position,
    input  logic signed [sxf_pkg::LEVEL_BITS-1:0] level_gain,

    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [SAMPLE_BITS-1:0]         mixed_sample,
    output logic                                  saturated
);

    localparam int S    = SAMPLE_BITS;
    localparam int G    = GAIN_FRAC_BITS;
    localparam int NS   = sxf_pkg::NUM_STAGES;
    localparam int SW   = sxf_pkg::SINE_BITS;
    localparam int QF   = sxf_pkg::SINE_FRAC;
    localparam int LB   = sxf_pkg::LEVEL_BITS;
    localparam int LF   = sxf_pkg::LEVEL_FRAC;
    localparam int ZQ   = sxf_pkg::ZQ_BITS;
    localparam int PB   = sxf_pkg::POS_BITS;
    localparam int SG_W = G + 3;
    localparam int LP_W = G + 1 + LB;
    localparam int PR_W = SG_W + S;
    localparam int SUM_W = PR_W + 1;
    localparam int Y_W  = S + 4;
    localparam int L    = sxf_pkg::LANE_LEFT;
    localparam int R    = sxf_pkg::LANE_RIGHT;

    sxf_pkg::pan_law_t pan_law_reg;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    // Stage payload registers.
    logic signed [S-1:0]  left_pipe_reg  [0:8];
    logic signed [S-1:0]  right_pipe_reg [0:8];
    logic signed [LB-1:0] lvl_pipe_reg   [0:7];
    logic [G-1:0]         lin_pipe_reg   [0:6][2];
    logic [SW-1:0]        z_pipe_reg     [0:5][2];
    logic [SW-1:0]        z2_pipe_reg    [1:4][2];
    logic [SW-1:0]        p_pipe_reg     [2:5][2];
    logic [SW:0]          sine_reg       [2];
    logic [G-1:0]         gain_reg       [2];
    logic signed [SG_W-1:0] scaled_reg  [2];
    logic signed [PR_W-1:0] prod_reg    [2];
    logic signed [Y_W-1:0]  y_reg;
    logic signed [S-1:0]    mixed_reg;
    logic                   sat_reg;

    // Combinational stage logic.
    logic [PB-1:0]     u_pos;
    logic [ZQ-1:0]     zq_in      [2];
    logic [G+PB-1:0]   u_shifted;
    logic [G-1:0]      lin_right;
    logic [G-1:0]      lin_left;
    logic [2*SW-1:0]   zz_prod    [2];
    logic [2*SW-1:0]   horner_prod [0:3][2];
    logic [2*SW-1:0]   sine_prod  [2];
    logic [SW+1:0]     sine_rnd   [2];
    logic [G+2:0]      sine_g     [2];
    logic [G-1:0]      sine_gain  [2];
    logic signed [LP_W-1:0] lvl_prod [2];
    logic signed [LP_W-1:0] lvl_rnd  [2];
    logic signed [SUM_W-1:0] sum_rnd;
    logic              y_over;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_law_reg <= sxf_pkg::PAN_SINE;
        end
        else if (cfg_valid)
        begin
            pan_law_reg <= sxf_pkg::pan_law_t'(pan_law);
        end
    end

    // A stage may load when it is empty or when the stage after it loads; the last one when result_stall is low.
    assign en[NS-1] = !valid_reg[NS-1] || !result_stall;
    for (genvar k = 0; k < NS - 1; k++)
    begin : g_enable
        assign en[k] = !valid_reg[k] || en[k+1];
    end
    assign item_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= item_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Position to the sine argument and the linear gains.
    always_comb
    begin
        u_pos            = {~fade_position[PB-1], fade_position[PB-2:0]};
        zq_in[R]         = {2'b00, u_pos[PB-1:1]};
        zq_in[L]         = (ZQ'(1) << PB) - zq_in[R];
        u_shifted        = {u_pos, {G{1'b0}}};
        lin_right        = u_shifted[G+PB-1:PB];
        lin_left         = (lin_right == '0) ? '1 : G'(-lin_right);
    end

    always_comb
    begin
        for (int n = 0; n < 2; n++)
        begin
            zz_prod[n] = z_pipe_reg[0][n] * z_pipe_reg[0][n];
            horner_prod[0][n] = (2*SW)'(sxf_pkg::SINE_C9) * z2_pipe_reg[1][n];
            for (int h = 1; h < sxf_pkg::HORNER_STEPS; h++)
            begin
                horner_prod[h][n] = p_pipe_reg[h+1][n] * z2_pipe_reg[h+1][n];
            end
            sine_prod[n] = p_pipe_reg[5][n] * z_pipe_reg[5][n];
            sine_rnd[n]  = {1'b0, sine_reg[n]} + ((SW+2)'(1) << (QF - 1 - G));
            sine_g[n]    = sine_rnd[n][SW+1:QF-G];
            sine_gain[n] = (|sine_g[n][G+2:G]) ? '1 : sine_g[n][G-1:0];
            lvl_prod[n]  = $signed({1'b0, gain_reg[n]}) * lvl_pipe_reg[7];
            lvl_rnd[n]   = lvl_prod[n] + LP_W'(1 << (LF - 1));
        end
        sum_rnd = SUM_W'(prod_reg[L]) + SUM_W'(prod_reg[R]) + (SUM_W'(1) <<< (G - 1));
        y_over  = (y_reg[Y_W-1:S-1] != {(Y_W-S+1){1'b0}})
               && (y_reg[Y_W-1:S-1] != {(Y_W-S+1){1'b1}});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            left_pipe_reg[0]   <= left_sample;
            right_pipe_reg[0]  <= right_sample;
            lvl_pipe_reg[0]    <= level_gain;
            lin_pipe_reg[0][L] <= lin_left;
            lin_pipe_reg[0][R] <= lin_right;
            for (int n = 0; n < 2; n++)
            begin
                z_pipe_reg[0][n] <= {zq_in[n], {(SW - ZQ){1'b0}}};
            end
        end

        for (int k = 1; k <= 8; k++)
        begin
            if (en[k])
            begin
                left_pipe_reg[k]  <= left_pipe_reg[k-1];
                right_pipe_reg[k] <= right_pipe_reg[k-1];
            end
        end
        for (int k = 1; k <= 7; k++)
        begin
            if (en[k])
            begin
                lvl_pipe_reg[k] <= lvl_pipe_reg[k-1];
            end
        end
        for (int k = 1; k <= 6; k++)
        begin
            if (en[k])
            begin
                lin_pipe_reg[k] <= lin_pipe_reg[k-1];
            end
        end
        for (int k = 1; k <= 5; k++)
        begin
            if (en[k])
            begin
                z_pipe_reg[k] <= z_pipe_reg[k-1];
            end
        end
        for (int k = 2; k <= 4; k++)
        begin
            if (en[k])
            begin
                z2_pipe_reg[k] <= z2_pipe_reg[k-1];
            end
        end

        for (int n = 0; n < 2; n++)
        begin
            if (en[1])
            begin
                z2_pipe_reg[1][n] <= zz_prod[n][2*SW-2:QF];
            end
            for (int h = 0; h < sxf_pkg::HORNER_STEPS; h++)
            begin
                if (en[h+2])
                begin
                    p_pipe_reg[h+2][n] <= sxf_pkg::SINE_COEF[h]
                                        - horner_prod[h][n][QF+SW-1:QF];
                end
            end
            if (en[6])
            begin
                sine_reg[n] <= sine_prod[n][QF+SW:QF];
            end
            if (en[7])
            begin
                gain_reg[n] <= (pan_law_reg == sxf_pkg::PAN_LINEAR)
                             ? lin_pipe_reg[6][n] : sine_gain[n];
            end
            if (en[8])
            begin
                scaled_reg[n] <= lvl_rnd[n][LP_W-1:LF];
            end
        end

        if (en[9])
        begin
            prod_reg[L] <= PR_W'(scaled_reg[L] * left_pipe_reg[8]);
            prod_reg[R] <= PR_W'(scaled_reg[R] * right_pipe_reg[8]);
        end
        if (en[10])
        begin
            y_reg <= sum_rnd[SUM_W-1:G];
        end
        if (en[11])
        begin
            sat_reg   <= y_over;
            mixed_reg <= y_over ? {y_reg[Y_W-1], {(S-1){~y_reg[Y_W-1]}}} : y_reg[S-1:0];
        end
    end

    assign result_valid = valid_reg[NS-1];
    assign mixed_sample = mixed_reg;
    assign saturated    = sat_reg;

endmodule
